### design/pcpa_pkg.sv
// Package for the per-CPU page allocator: sizes, command and status codes,
// the queue entry type and the back-end state enum. No dependencies.
package pcpa_pkg;

    localparam int NUM_PAGES = 32768;
    localparam int NUM_CPUS  = 8;
    localparam int PW        = $clog2(NUM_PAGES);
    localparam int CW        = $clog2(NUM_CPUS);
    localparam logic [6:0]  STEAL_BATCH_RST  = 7'd10;
    localparam logic [15:0] USABLE_PAGES_RST = 16'd32768;
    localparam logic [15:0] CNT_MAX          = 16'hFFFF;
    localparam int QDEPTH = 2;

    typedef enum logic [2:0] {
        CMD_ALLOC = 3'd0,
        CMD_FREE  = 3'd1,
        CMD_SEED  = 3'd2,
        CMD_INC   = 3'd3,
        CMD_GET   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFREE  = 2'd1,
        ST_INVALID = 2'd2,
        ST_SHARED  = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        CFG_STEAL  = 1'b0,
        CFG_USABLE = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0]    cmd;
        logic [CW-1:0] cpu;
        logic [14:0]   page;
        logic          page_ok;
    } qent_t;

    typedef enum logic [3:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_SCAN,
        BS_WALK_RD,
        BS_WALK,
        BS_STEAL_DONE,
        BS_POP_RD,
        BS_POP,
        BS_REF_RD,
        BS_REF,
        BS_OUT
    } bstate_t;

endpackage

### design/pcpa_front.sv
// Front end: accepts command transactions, reduces the CPU number and checks
// the page range, then queues them. Uses pcpa_pkg.
module pcpa_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    output logic                 ready,
    input  logic [2:0]           cmd,
    input  logic [2:0]           cpu_id,
    input  logic [14:0]          page_index,
    input  logic [15:0]          usable_pages,
    output logic                 q_valid,
    input  logic                 q_ready,
    output pcpa_pkg::qent_t      q_data
);

    pcpa_pkg::qent_t q_reg [pcpa_pkg::QDEPTH];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;
    logic [16:0] lim;
    pcpa_pkg::qent_t ent;

    always_comb
    begin
        lim = (usable_pages > 16'(pcpa_pkg::NUM_PAGES)) ? 17'(pcpa_pkg::NUM_PAGES)
                                                        : {1'b0, usable_pages};
        ent.cmd     = cmd;
        ent.cpu     = cpu_id[pcpa_pkg::CW-1:0];
        ent.page    = page_index;
        ent.page_ok = {2'b0, page_index} < lim;
    end

    assign ready   = cnt_reg != 2'(pcpa_pkg::QDEPTH);
    assign push    = valid && ready;
    assign q_valid = cnt_reg != 2'd0;
    assign pop     = q_valid && q_ready;
    assign q_data  = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

### design/pcpa_back.sv
// Back end: carries out queued commands on the link memory, the count
// memory and the per-CPU list registers, and holds the result. Uses pcpa_pkg.
module pcpa_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  pcpa_pkg::qent_t      q_data,
    input  logic [6:0]           steal_batch,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [14:0]          page_out,
    output logic [15:0]          ref_count
);

    localparam int PW = pcpa_pkg::PW;
    localparam int CW = pcpa_pkg::CW;

    logic [14:0] link_mem [pcpa_pkg::NUM_PAGES];
    logic [15:0] ref_mem  [pcpa_pkg::NUM_PAGES];

    logic [14:0] head_reg [pcpa_pkg::NUM_CPUS];
    logic [15:0] size_reg [pcpa_pkg::NUM_CPUS];

    pcpa_pkg::bstate_t st_reg, st_next;
    pcpa_pkg::qent_t   e_reg, e_next;
    logic [PW-1:0] clr_reg, clr_next;
    logic [CW-1:0] src_reg, src_next;
    logic [15:0]   n_reg, n_next;
    logic [6:0]    k_reg, k_next;
    logic [14:0]   cur_reg, cur_next;
    logic [PW-1:0] raddr;
    logic          rd_link, rd_ref;
    logic [14:0]   link_q;
    logic [15:0]   ref_raw, ref_q;
    logic [1:0]    status_reg, status_next;
    logic [14:0]   page_reg, page_next;
    logic [15:0]   cnt_reg, cnt_next;
    logic          ov_reg;

    logic          lw_en, rw_en;
    logic [PW-1:0] lw_addr, rw_addr;
    logic [14:0]   lw_data;
    logic [15:0]   rw_data;

    logic          hw_en, sw_en, h2_en, s2_en;
    logic [CW-1:0] hw_cpu, h2_cpu;
    logic [14:0]   hw_val, h2_val;
    logic [15:0]   sw_val, s2_val;
    logic [6:0]    batch;
    logic [15:0]   own_size;

    assign batch    = (steal_batch == 7'd0) ? 7'd1 : steal_batch;
    assign own_size = size_reg[e_reg.cpu];
    assign ref_q    = ref_raw;

    always_ff @(posedge clk)
    begin
        if (rd_link)
        begin
            link_q <= link_mem[raddr];
        end
        if (rd_ref)
        begin
            ref_raw <= ref_mem[raddr];
        end
        if (lw_en)
        begin
            link_mem[lw_addr] <= lw_data;
        end
        if (rw_en)
        begin
            ref_mem[rw_addr] <= rw_data;
        end
    end

    always_comb
    begin
        st_next     = st_reg;
        e_next      = e_reg;
        clr_next    = clr_reg;
        src_next    = src_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        cur_next    = cur_reg;
        status_next = status_reg;
        page_next   = page_reg;
        cnt_next    = cnt_reg;
        q_ready     = 1'b0;
        rd_link     = 1'b0;
        rd_ref      = 1'b0;
        raddr       = '0;
        lw_en = 1'b0; lw_addr = '0; lw_data = '0;
        rw_en = 1'b0; rw_addr = '0; rw_data = '0;
        hw_en = 1'b0; hw_cpu = '0; hw_val = '0;
        sw_en = 1'b0; sw_val = '0;
        h2_en = 1'b0; h2_cpu = '0; h2_val = '0;
        s2_en = 1'b0; s2_val = '0;
        unique case (st_reg)
            pcpa_pkg::BS_CLEAR:
            begin
                rw_en    = 1'b1;
                rw_addr  = clr_reg;
                rw_data  = 16'd0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    st_next = pcpa_pkg::BS_IDLE;
                end
            end
            pcpa_pkg::BS_IDLE:
            begin
                q_ready = !ov_reg;
                if (q_valid && !ov_reg)
                begin
                    e_next      = q_data;
                    status_next = pcpa_pkg::ST_OK;
                    page_next   = q_data.page;
                    cnt_next    = '0;
                    src_next    = '0;
                    if (q_data.cmd == pcpa_pkg::CMD_ALLOC)
                    begin
                        st_next = (size_reg[q_data.cpu] == 16'd0) ? pcpa_pkg::BS_SCAN
                                                                  : pcpa_pkg::BS_POP_RD;
                    end
                    else if (q_data.cmd > pcpa_pkg::CMD_GET)
                    begin
                        st_next = pcpa_pkg::BS_OUT;
                    end
                    else if (!q_data.page_ok)
                    begin
                        status_next = pcpa_pkg::ST_INVALID;
                        st_next     = pcpa_pkg::BS_OUT;
                    end
                    else
                    begin
                        st_next = pcpa_pkg::BS_REF_RD;
                    end
                end
            end
            pcpa_pkg::BS_SCAN:
            begin
                if (src_reg != e_reg.cpu && size_reg[src_reg] != 16'd0)
                begin
                    n_next   = (size_reg[src_reg] > 16'(batch)) ? 16'(batch)
                                                                : size_reg[src_reg];
                    cur_next = head_reg[src_reg];
                    k_next   = '0;
                    st_next  = pcpa_pkg::BS_WALK_RD;
                end
                else if (src_reg == CW'(pcpa_pkg::NUM_CPUS - 1))
                begin
                    status_next = pcpa_pkg::ST_NOFREE;
                    page_next   = '0;
                    st_next     = pcpa_pkg::BS_OUT;
                end
                else
                begin
                    src_next = src_reg + 1'b1;
                end
            end
            pcpa_pkg::BS_WALK_RD:
            begin
                rd_link = 1'b1;
                raddr   = cur_reg[PW-1:0];
                st_next = pcpa_pkg::BS_WALK;
            end
            pcpa_pkg::BS_WALK:
            begin
                cur_next = link_q;
                k_next   = k_reg + 1'b1;
                st_next  = (16'(k_reg) + 16'd1 == n_reg) ? pcpa_pkg::BS_STEAL_DONE
                                                          : pcpa_pkg::BS_WALK_RD;
            end
            pcpa_pkg::BS_STEAL_DONE:
            begin
                hw_en  = 1'b1; hw_cpu = e_reg.cpu; hw_val = head_reg[src_reg];
                sw_en  = 1'b1; sw_val = n_reg;
                h2_en  = 1'b1; h2_cpu = src_reg; h2_val = cur_reg;
                s2_en  = 1'b1; s2_val = size_reg[src_reg] - n_reg;
                st_next = pcpa_pkg::BS_POP_RD;
            end
            pcpa_pkg::BS_POP_RD:
            begin
                rd_link   = 1'b1;
                rd_ref    = 1'b1;
                raddr     = head_reg[e_reg.cpu][PW-1:0];
                page_next = head_reg[e_reg.cpu];
                st_next   = pcpa_pkg::BS_POP;
            end
            pcpa_pkg::BS_POP:
            begin
                hw_en  = 1'b1; hw_cpu = e_reg.cpu; hw_val = link_q;
                sw_en  = 1'b1; sw_val = own_size - 16'd1;
                cnt_next = ref_q;
                rw_en   = 1'b1;
                rw_addr = page_reg[PW-1:0];
                rw_data = (ref_q == pcpa_pkg::CNT_MAX) ? ref_q : ref_q + 16'd1;
                st_next = pcpa_pkg::BS_OUT;
            end
            pcpa_pkg::BS_REF_RD:
            begin
                rd_ref  = 1'b1;
                raddr   = e_reg.page[PW-1:0];
                st_next = pcpa_pkg::BS_REF;
            end
            pcpa_pkg::BS_REF:
            begin
                cnt_next = ref_q;
                rw_addr  = e_reg.page[PW-1:0];
                lw_addr  = e_reg.page[PW-1:0];
                lw_data  = head_reg[e_reg.cpu];
                hw_cpu   = e_reg.cpu;
                hw_val   = e_reg.page;
                sw_val   = (own_size == pcpa_pkg::CNT_MAX) ? own_size : own_size + 16'd1;
                if (e_reg.cmd == pcpa_pkg::CMD_FREE)
                begin
                    rw_en   = 1'b1;
                    rw_data = (ref_q == 16'd0) ? 16'd0 : ref_q - 16'd1;
                    if (ref_q <= 16'd1)
                    begin
                        lw_en = 1'b1; hw_en = 1'b1; sw_en = 1'b1;
                    end
                    else
                    begin
                        status_next = pcpa_pkg::ST_SHARED;
                    end
                end
                else if (e_reg.cmd == pcpa_pkg::CMD_SEED)
                begin
                    lw_en = 1'b1; hw_en = 1'b1; sw_en = 1'b1;
                end
                else if (e_reg.cmd == pcpa_pkg::CMD_INC)
                begin
                    rw_en   = 1'b1;
                    rw_data = (ref_q == pcpa_pkg::CNT_MAX) ? ref_q : ref_q + 16'd1;
                end
                st_next = pcpa_pkg::BS_OUT;
            end
            pcpa_pkg::BS_OUT:
            begin
                if (!ov_reg)
                begin
                    st_next = pcpa_pkg::BS_IDLE;
                end
            end
            default:
            begin
                st_next = pcpa_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        e_reg      <= e_next;
        src_reg    <= src_next;
        n_reg      <= n_next;
        k_reg      <= k_next;
        cur_reg    <= cur_next;
        status_reg <= status_next;
        page_reg   <= page_next;
        cnt_reg    <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= pcpa_pkg::BS_CLEAR;
            clr_reg <= '0;
            ov_reg  <= 1'b0;
            for (int i = 0; i < pcpa_pkg::NUM_CPUS; i++)
            begin
                head_reg[i] <= '0;
                size_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg  <= st_next;
            clr_reg <= clr_next;
            if (st_reg == pcpa_pkg::BS_OUT && !ov_reg)
            begin
                ov_reg <= 1'b1;
            end
            else if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (hw_en)
            begin
                head_reg[hw_cpu] <= hw_val;
            end
            if (sw_en)
            begin
                size_reg[hw_cpu] <= sw_val;
            end
            if (h2_en)
            begin
                head_reg[h2_cpu] <= h2_val;
            end
            if (s2_en)
            begin
                size_reg[h2_cpu] <= s2_val;
            end
        end
    end

    assign out_valid = ov_reg;
    assign status    = status_reg;
    assign page_out  = page_reg;
    assign ref_count = cnt_reg;

endmodule

### design/per_cpu_page_allocator_refcount.sv
// Top level of the per-CPU page allocator with page reference counts.
// Holds the configuration registers and joins pcpa_front and pcpa_back.
//
// Channels: a command channel (valid/ready with cmd, cpu_id, page_index), a
// result channel (out_valid/out_ready with status, page_out, ref_count) and
// a configuration write channel (cfg_valid/cfg_ready with cfg_index, cfg_data).
// Each command transaction gives exactly one result transaction, in order.
// Commands pass through a two-entry queue into a back end that works on one
// at a time. The back end takes the next command only after the previous
// result has been taken. An alloc from an empty list first scans the other
// CPUs for a non-empty list, walks the link memory over the pages to be
// moved and relinks the lists; an alloc that finds no page anywhere gives a
// no-free result. Reset empties all lists and loads steal_batch 10 and
// usable_pages 32768. A clearing pass then zeroes every count before the
// first command is taken. The link memory is not cleared. When the receiver
// stalls, the result holds in the output register and the back end waits;
// the queue keeps taking commands until full.
module per_cpu_page_allocator_refcount (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [2:0]  cmd,
    input  logic [2:0]  cpu_id,
    input  logic [14:0] page_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [14:0] page_out,
    output logic [15:0] ref_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [6:0]  steal_batch_reg;
    logic [15:0] usable_pages_reg;
    logic q_valid, q_ready;
    pcpa_pkg::qent_t q_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steal_batch_reg  <= pcpa_pkg::STEAL_BATCH_RST;
            usable_pages_reg <= pcpa_pkg::USABLE_PAGES_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == pcpa_pkg::CFG_STEAL)
            begin
                steal_batch_reg <= cfg_data[6:0];
            end
            else
            begin
                usable_pages_reg <= cfg_data;
            end
        end
    end

    pcpa_front u_front (
        .clk, .rst_n, .valid, .ready, .cmd, .cpu_id, .page_index,
        .usable_pages(usable_pages_reg),
        .q_valid, .q_ready, .q_data
    );

    pcpa_back u_back (
        .clk, .rst_n, .q_valid, .q_ready, .q_data,
        .steal_batch(steal_batch_reg),
        .out_valid, .out_ready, .status, .page_out, .ref_count
    );

`ifndef ASSERT_OFF
    a_nofree_page: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pcpa_pkg::ST_NOFREE |-> page_out == 15'd0)
        else $error("no-free result carries a page");
    a_invalid_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pcpa_pkg::ST_INVALID |-> ref_count == 16'd0)
        else $error("invalid page result carries a count");
    a_shared_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pcpa_pkg::ST_SHARED |-> ref_count > 16'd1)
        else $error("shared status with count at most one");
`endif

endmodule
